FILE: design/packet_hash_check_top_assert.svh
// Assertion macros shared by the packet hash check modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PACKET_HASH_CHECK_TOP_ASSERT_SVH
`define PACKET_HASH_CHECK_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PHC_ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PHC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/phc_pkg.sv
`timescale 1ns / 1ps
// Shared types, header layout constants and hash functions for the packet hash check.
// No dependencies.
package phc_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 512;
  localparam int LEN_W = 10;

  localparam int CHK_BYTES = 4;
  localparam int TYPE_OFF  = 4;
  localparam int SEQ_OFF   = 5;
  localparam int ACK_OFF   = 9;
  localparam int HDR_BYTES = 13;

  localparam int HASH_SHL_MIX = 10;
  localparam int HASH_ASR_MIX = 6;
  localparam int HASH_SHL_FIN1 = 3;
  localparam int HASH_ASR_FIN = 11;
  localparam int HASH_SHL_FIN2 = 15;

  typedef struct packed {
    logic [31:0]        hash;
    logic [31:0]        checksum;
    logic               short_chk;
    logic               short_hdr;
    logic [7:0]         ptype;
    logic [31:0]        seq;
    logic [31:0]        ack;
    logic [LEN_W-1:0]   length;
  } phc_sum_t;

  function automatic logic [31:0] oaat_mix(logic [31:0] h, logic [7:0] b);
    logic [31:0] t;
    t = h + {{24{b[7]}}, b};
    t = t + (t << HASH_SHL_MIX);
    t = t ^ 32'($signed(t) >>> HASH_ASR_MIX);
    return t;
  endfunction

  function automatic logic [31:0] oaat_final(logic [31:0] h);
    logic [31:0] t;
    t = h + (h << HASH_SHL_FIN1);
    t = t ^ 32'($signed(t) >>> HASH_ASR_FIN);
    t = t + (t << HASH_SHL_FIN2);
    return t;
  endfunction

endpackage

FILE: design/phc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for packet bytes and check results.
// No dependencies.
interface phc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface phc_out_if;
  logic               valid;
  logic               ready;
  logic               corrupt;
  logic               header_short;
  logic [7:0]         packet_type;
  logic signed [31:0] packet_sequence;
  logic signed [31:0] acknowledge_sequence;
  logic [9:0]         packet_length;

  modport source (output valid, output corrupt, output header_short, output packet_type,
                  output packet_sequence, output acknowledge_sequence,
                  output packet_length, input ready);
  modport sink (input valid, input corrupt, input header_short, input packet_type,
                input packet_sequence, input acknowledge_sequence,
                input packet_length, output ready);
endinterface

FILE: design/phc_accum.sv
`timescale 1ns / 1ps
// Per-byte packet state: header capture, checksum capture, byte count and running hash.
// Depends on phc_pkg and the assertion macro header.
`include "packet_hash_check_top_assert.svh"

module phc_accum
  import phc_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  logic [7:0] data_byte,
  input  logic     last_byte,
  output logic     done,
  output phc_sum_t sum
);

  localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [31:0]      hash, hash_next;
  logic [31:0]      checksum, checksum_next;
  logic [CNT_W-1:0] count, count_next;
  logic [7:0]       ptype, ptype_next;
  logic [31:0]      seq, seq_next;
  logic [31:0]      ack, ack_next;

  logic [CNT_W-1:0] seq_sel;
  logic [CNT_W-1:0] ack_sel;
  logic [CNT_W+LEN_W-1:0] len_ext;

  assign seq_sel = count - CNT_W'(SEQ_OFF);
  assign ack_sel = count - CNT_W'(ACK_OFF);

  always_comb begin
    hash_next     = hash;
    checksum_next = checksum;
    ptype_next    = ptype;
    seq_next      = seq;
    ack_next      = ack;
    if (count < CNT_W'(CHK_BYTES)) begin
      checksum_next = checksum | (32'(data_byte) << {count[1:0], 3'b000});
    end else begin
      hash_next = oaat_mix(hash, data_byte);
      if (count == CNT_W'(TYPE_OFF)) begin
        ptype_next = data_byte;
      end else if (count >= CNT_W'(SEQ_OFF) && count < CNT_W'(ACK_OFF)) begin
        seq_next = seq | (32'(data_byte) << {seq_sel[1:0], 3'b000});
      end else if (count >= CNT_W'(ACK_OFF) && count < CNT_W'(HDR_BYTES)) begin
        ack_next = ack | (32'(data_byte) << {ack_sel[1:0], 3'b000});
      end
    end
    count_next = (count < CNT_W'(MAX_PACKET_BYTES)) ? count + CNT_W'(1) : count;
  end

  assign len_ext = {{LEN_W{1'b0}}, count_next};

  assign done = accept && last_byte;

  always_comb begin
    sum.hash      = hash_next;
    sum.checksum  = checksum_next;
    sum.short_chk = count_next < CNT_W'(CHK_BYTES);
    sum.short_hdr = count_next < CNT_W'(HDR_BYTES);
    sum.ptype     = ptype_next;
    sum.seq       = seq_next;
    sum.ack       = ack_next;
    sum.length    = len_ext[LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || done) begin
      hash     <= '0;
      checksum <= '0;
      count    <= '0;
      ptype    <= '0;
      seq      <= '0;
      ack      <= '0;
    end else if (accept) begin
      hash     <= hash_next;
      checksum <= checksum_next;
      count    <= count_next;
      ptype    <= ptype_next;
      seq      <= seq_next;
      ack      <= ack_next;
    end
  end

  `PHC_ASSERT_NEXT(a_clear_after_last, clk, rst, done, count == '0 && hash == '0 && checksum == '0, "state not cleared after last byte")
  `PHC_ASSERT_NEXT(a_count_step, clk, rst, accept && !last_byte && count != CNT_W'(MAX_PACKET_BYTES), count == $past(count) + CNT_W'(1), "byte count did not advance")
  `PHC_ASSERT_IMPLY(a_hash_idle_in_checksum, clk, rst, count < CNT_W'(CHK_BYTES), hash == '0, "hash moved during checksum bytes")

endmodule

FILE: design/phc_finish.sv
`timescale 1ns / 1ps
// Final hash mixing, checksum compare and result register.
// Depends on phc_pkg, phc_if and the assertion macro header.
`include "packet_hash_check_top_assert.svh"

module phc_finish
  import phc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  phc_sum_t sum,
  output logic     ready,
  phc_out_if.source result
);

  logic        f_valid;
  phc_sum_t    f_sum;
  logic        f_adv;
  logic [31:0] f_hash;

  logic               out_valid;
  logic               out_corrupt;
  logic               out_short;
  logic [7:0]         out_type;
  logic signed [31:0] out_seq;
  logic signed [31:0] out_ack;
  logic [LEN_W-1:0]   out_len;

  assign f_adv  = f_valid && (!out_valid || result.ready);
  assign ready  = !f_valid || f_adv;
  assign f_hash = oaat_final(f_sum.hash);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        f_valid <= 1'b1;
      end else if (f_adv) begin
        f_valid <= 1'b0;
      end
      if (f_adv) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (load) begin
      f_sum <= sum;
    end
    if (f_adv) begin
      out_corrupt <= f_sum.short_chk || (f_hash != f_sum.checksum);
      out_short   <= f_sum.short_hdr;
      out_type    <= f_sum.ptype;
      out_seq     <= $signed(f_sum.seq);
      out_ack     <= $signed(f_sum.ack);
      out_len     <= f_sum.length;
    end
  end

  assign result.valid                = out_valid;
  assign result.corrupt              = out_corrupt;
  assign result.header_short         = out_short;
  assign result.packet_type          = out_type;
  assign result.packet_sequence      = out_seq;
  assign result.acknowledge_sequence = out_ack;
  assign result.packet_length        = out_len;

  `PHC_ASSERT_IMPLY(a_no_overrun, clk, rst, load, !f_valid || f_adv, "finish stage overwritten")
  `PHC_ASSERT_NEXT(a_stage_holds, clk, rst, f_valid && !f_adv, f_valid, "finish stage dropped a packet")
  `PHC_ASSERT_NEXT(a_advance_shows, clk, rst, f_adv, out_valid, "advanced packet not presented")

endmodule

FILE: design/packet_hash_check_top.sv
`timescale 1ns / 1ps
// Top level of the packet hash check: byte input channel, result output channel.
// Depends on phc_pkg, phc_if, phc_accum and phc_finish.
//
// The block takes one packet byte per clock while input ready is high and gives one result per
// packet. The byte marked last is folded into the running hash and header captures of the
// accumulate stage on its way into the finish stage, and the final mixing and checksum compare
// sit between the finish stage and the result register, which holds the outcome until taken.
// Input ready drops only when a finished packet sits in the finish stage while the result
// register is full and not being taken. The byte count register is $clog2(MAX_PACKET_BYTES + 1)
// bits and saturates at MAX_PACKET_BYTES; packet_length reports its low 10 bits.
module packet_hash_check_top
  import phc_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst,
  phc_in_if.sink   packet,
  phc_out_if.source result
);

  logic     accept;
  logic     done;
  logic     fin_ready;
  phc_sum_t sum;

  assign packet.ready = fin_ready;
  assign accept       = packet.valid && fin_ready;

  phc_accum #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (packet.data_byte),
    .last_byte (packet.last_byte),
    .done      (done),
    .sum       (sum)
  );

  phc_finish u_finish (
    .clk    (clk),
    .rst    (rst),
    .load   (done),
    .sum    (sum),
    .ready  (fin_ready),
    .result (result)
  );

endmodule
